// File: rtl/restoring_integer_divider_macros.svh
// ---------------------------------------------------------------------------
// Restoring integer divider assertion macros
// Shared assertion forms, clocked on clk and held off during rst.
// ---------------------------------------------------------------------------
`ifndef RESTORING_INTEGER_DIVIDER_MACROS_SVH
`define RESTORING_INTEGER_DIVIDER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RID_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("restoring_integer_divider: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define RID_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("restoring_integer_divider: next-cycle check failed");

`endif

// File: rtl/rid_pkg.sv
// ---------------------------------------------------------------------------
// Restoring integer divider package
// Operation codes, field widths and control types shared by the divider.
// ---------------------------------------------------------------------------
package rid_pkg;

  localparam int DATA_W        = 32;
  localparam int FUNC_W        = 2;
  localparam int DEFAULT_WIDTH = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_DIVU = 2'd0,
    FUNC_REMU = 2'd1,
    FUNC_DIV  = 2'd2,
    FUNC_REM  = 2'd3
  } func_t;

  // control that rides along the step stages
  typedef struct packed {
    logic want_rem;
    logic flip;
  } rid_ctl_t;

endpackage

// File: rtl/rid_prep.sv
// ---------------------------------------------------------------------------
// Divider front stage
// Decodes the operation, takes operand magnitudes and registers the request.
// ---------------------------------------------------------------------------
module rid_prep import rid_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [DATA_W-1:0] in_dividend,
  input  logic [DATA_W-1:0] in_divisor,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WIDTH-1:0]  out_aq,
  output logic [WIDTH-1:0]  out_r,
  output logic [WIDTH-1:0]  out_d,
  output rid_ctl_t          out_ctl
);

  logic [DATA_W+WIDTH-1:0] a_ext;
  logic [DATA_W+WIDTH-1:0] d_ext;
  logic [WIDTH-1:0]        a_raw;
  logic [WIDTH-1:0]        d_raw;
  logic                    is_signed;
  logic                    want_rem;
  logic                    a_neg;
  logic                    d_neg;
  logic [WIDTH-1:0]        a_mag;
  logic [WIDTH-1:0]        d_mag;
  rid_ctl_t                ctl_next;

  always_comb begin
    // fit the 32-bit fields to the working width
    a_ext     = {{WIDTH{1'b0}}, in_dividend};
    d_ext     = {{WIDTH{1'b0}}, in_divisor};
    a_raw     = a_ext[WIDTH-1:0];
    d_raw     = d_ext[WIDTH-1:0];
    is_signed = (in_func == FUNC_DIV) || (in_func == FUNC_REM);
    want_rem  = (in_func == FUNC_REMU) || (in_func == FUNC_REM);
    a_neg     = is_signed & a_raw[WIDTH-1];
    d_neg     = is_signed & d_raw[WIDTH-1];
    a_mag     = a_neg ? (~a_raw + WIDTH'(1)) : a_raw;
    d_mag     = d_neg ? (~d_raw + WIDTH'(1)) : d_raw;
    ctl_next.want_rem = want_rem;
    ctl_next.flip     = want_rem ? a_neg : (a_neg ^ d_neg);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_aq  <= a_mag;
      out_r   <= '0;
      out_d   <= d_mag;
      out_ctl <= ctl_next;
    end
  end

endmodule

// File: rtl/rid_step.sv
// ---------------------------------------------------------------------------
// Divider step stage
// One restoring step: shift in a dividend bit, trial subtract, keep or restore.
// ---------------------------------------------------------------------------
module rid_step import rid_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_aq,
  input  logic [WIDTH-1:0] in_r,
  input  logic [WIDTH-1:0] in_d,
  input  rid_ctl_t         in_ctl,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_aq,
  output logic [WIDTH-1:0] out_r,
  output logic [WIDTH-1:0] out_d,
  output rid_ctl_t         out_ctl
);

  // aq holds the dividend bits not yet used on top, quotient bits below
  logic [WIDTH:0]   r_cat;
  logic [WIDTH:0]   aq_cat;
  logic [WIDTH-1:0] ext;
  logic [WIDTH:0]   diff;
  logic             take;
  logic [WIDTH-1:0] r_next;
  logic [WIDTH-1:0] aq_next;

  always_comb begin
    r_cat   = {in_r, in_aq[WIDTH-1]};
    ext     = r_cat[WIDTH-1:0];
    diff    = {1'b0, ext} - {1'b0, in_d};
    take    = !diff[WIDTH];
    r_next  = take ? diff[WIDTH-1:0] : ext;
    aq_cat  = {in_aq, take};
    aq_next = aq_cat[WIDTH-1:0];
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_aq  <= aq_next;
      out_r   <= r_next;
      out_d   <= in_d;
      out_ctl <= in_ctl;
    end
  end

endmodule

// File: rtl/rid_post.sv
// ---------------------------------------------------------------------------
// Divider output stage
// Selects quotient or remainder, applies the sign and holds the result.
// ---------------------------------------------------------------------------
module rid_post import rid_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WIDTH-1:0]  in_q,
  input  logic [WIDTH-1:0]  in_r,
  input  rid_ctl_t          in_ctl,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_result
);

  logic [WIDTH-1:0]        sel;
  logic [WIDTH-1:0]        fixed;
  logic [DATA_W+WIDTH-1:0] res_ext;

  always_comb begin
    sel     = in_ctl.want_rem ? in_r : in_q;
    fixed   = in_ctl.flip ? (~sel + WIDTH'(1)) : sel;
    res_ext = {{DATA_W{1'b0}}, fixed};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_result <= res_ext[DATA_W-1:0];
    end
  end

endmodule

// File: rtl/restoring_integer_divider.sv
// ---------------------------------------------------------------------------
// Restoring integer divider
// Signed and unsigned divide and remainder, one request per unstalled cycle.
// ---------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled, and returns
// one result per request in order. The pipeline has one front stage that
// decodes func and forms operand magnitudes, one register stage per
// quotient bit (a WIDTH-bit trial subtract each), and one output stage that
// picks quotient or remainder and restores the sign. Each stage holds its
// request until the next stage can take it, so empty stages keep accepting
// new requests while a result waits at the output. Division truncates toward
// zero; a zero divisor gives an all-ones magnitude quotient and the dividend
// as remainder, and the most negative value over minus one wraps to itself.
`include "restoring_integer_divider_macros.svh"

module restoring_integer_divider import rid_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [2*DATA_W-1:0] s_axis_tdata,   // dividend[31:0], divisor[63:32]
  input  logic [FUNC_W-1:0]   s_axis_tuser,   // func[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [DATA_W-1:0]   m_axis_tdata    // result[31:0]
);

  logic             st_valid [0:WIDTH];
  logic             st_ready [0:WIDTH];
  logic [WIDTH-1:0] st_aq    [0:WIDTH];
  logic [WIDTH-1:0] st_r     [0:WIDTH];
  logic [WIDTH-1:0] st_d     [0:WIDTH];
  rid_ctl_t         st_ctl   [0:WIDTH];

  rid_prep #(
    .WIDTH (WIDTH)
  ) u_prep (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_func     (s_axis_tuser),
    .in_dividend (s_axis_tdata[DATA_W-1:0]),
    .in_divisor  (s_axis_tdata[2*DATA_W-1:DATA_W]),
    .out_valid   (st_valid[0]),
    .out_ready   (st_ready[0]),
    .out_aq      (st_aq[0]),
    .out_r       (st_r[0]),
    .out_d       (st_d[0]),
    .out_ctl     (st_ctl[0])
  );

  for (genvar k = 0; k < WIDTH; k++) begin : g_step
    rid_step #(
      .WIDTH (WIDTH)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (st_valid[k]),
      .in_ready  (st_ready[k]),
      .in_aq     (st_aq[k]),
      .in_r      (st_r[k]),
      .in_d      (st_d[k]),
      .in_ctl    (st_ctl[k]),
      .out_valid (st_valid[k+1]),
      .out_ready (st_ready[k+1]),
      .out_aq    (st_aq[k+1]),
      .out_r     (st_r[k+1]),
      .out_d     (st_d[k+1]),
      .out_ctl   (st_ctl[k+1])
    );
  end

  rid_post #(
    .WIDTH (WIDTH)
  ) u_post (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (st_valid[WIDTH]),
    .in_ready   (st_ready[WIDTH]),
    .in_q       (st_aq[WIDTH]),
    .in_r       (st_r[WIDTH]),
    .in_ctl     (st_ctl[WIDTH]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (m_axis_tdata)
  );

  // an empty output register frees the whole ready chain
  `RID_ASSERT_NOW(a_ready_when_out_empty, !m_axis_tvalid, s_axis_tready)
  // finished remainder is below the divisor unless dividing by zero
  `RID_ASSERT_NOW(a_rem_below_divisor, st_valid[WIDTH],
    (st_r[WIDTH] < st_d[WIDTH]) || (st_d[WIDTH] == '0))
  // a request handed to the output stage shows up on the output next cycle
  `RID_ASSERT_NEXT(a_post_load, st_valid[WIDTH] && st_ready[WIDTH], m_axis_tvalid)

endmodule
